### rtl/core/lbp3_pkg.sv
// ----------------------------------------------------------------------------
// lbp3_pkg
// Shared widths, register indexes and the item flags handed between stages
// of the 3x3 local binary pattern core.
// ----------------------------------------------------------------------------
package lbp3_pkg;

  localparam int PIX_W  = 8;
  localparam int CODE_W = 8;
  localparam int ROW_W  = 16;
  localparam int CFGW_W = 11;
  localparam int CFG_W  = 16;

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // per-item flags carried from the input stage to the window stage
  typedef struct packed {
    logic emit;      // this item releases one code
    logic col_zero;  // item sits in column zero, right neighbour is outside
  } lbp3_item_t;

endpackage

### rtl/core/local_binary_pattern_3x3_core.sv
// ----------------------------------------------------------------------------
// local_binary_pattern_3x3_core
// 8-neighbour local binary pattern over a raster stream of grey pixels,
// built around two line-store memories with a registered read.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the output is not stalled; each store has one read and one write a cycle
// order: a code is registered as the item that releases it leaves the stage
//   register; that item comes one row plus one pixel after the code's own pixel
// reset: counters, window, valids cleared; width min(640, MAX_WIDTH), height 240;
//   line stores are not cleared and need no sweep
module local_binary_pattern_3x3_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [lbp3_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] pixel
  input  logic                       in_tuser,   // [0] mode
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] lbp_code
  output logic                       out_tlast   // frame_last
);
  import lbp3_pkg::*;

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int RESET_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;

  logic [WW-1:0]    w_eff_r;
  logic [ROW_W-1:0] h_eff_r;

  logic             advance;
  logic             accept;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             s1_valid;
  lbp3_item_t       s1_item;
  logic [PIX_W-1:0] s1_pix;
  logic [AW-1:0]    s1_addr;
  logic [PIX_W-1:0] top, mid;
  logic [CFGW_W-1:0] wval;

  assign wval = cfg_wdata[CFGW_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= WW'(RESET_W);
      h_eff_r <= ROW_W'(240);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (wval == '0) begin
            w_eff_r <= WW'(1);
          end else if (32'(wval) > 32'(MAX_WIDTH)) begin
            w_eff_r <= WW'(MAX_WIDTH);
          end else begin
            w_eff_r <= WW'(wval);
          end
        end
        REG_IMAGE_HEIGHT: begin
          h_eff_r <= (cfg_wdata == '0) ? ROW_W'(1) : cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // the pipe moves whenever the output slot is free or being emptied
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance;
  assign accept    = in_tvalid && advance;

  lbp3_input_seq #(.MAX_WIDTH(MAX_WIDTH)) u_input_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .w_eff    (w_eff_r),
    .h_eff    (h_eff_r),
    .restart  (cfg_we),
    .accept   (accept),
    .advance  (advance),
    .mode     (in_tuser),
    .pixel    (in_tdata),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_pix   (s1_pix),
    .s1_addr  (s1_addr)
  );

  lbp3_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (s1_valid && advance),
    .wr_addr (s1_addr),
    .wr_pix  (s1_pix),
    .top     (top),
    .mid     (mid)
  );

  lbp3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .w_eff     (w_eff_r),
    .h_eff     (h_eff_r),
    .restart   (cfg_we),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_pix    (s1_pix),
    .top       (top),
    .mid       (mid),
    .out_valid (out_tvalid),
    .out_code  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

### rtl/core/lbp3_input_seq.sv
// ----------------------------------------------------------------------------
// lbp3_input_seq
// Input raster position, flush filtering and the stage register that holds
// an item while its line-store read is in flight.
// ----------------------------------------------------------------------------
module lbp3_input_seq #(
  parameter int MAX_WIDTH = 1024,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [WW-1:0]             w_eff,
  input  logic [lbp3_pkg::ROW_W-1:0] h_eff,
  input  logic                      restart,
  input  logic                      accept,
  input  logic                      advance,
  input  logic                      mode,
  input  logic [lbp3_pkg::PIX_W-1:0] pixel,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  output logic                      s1_valid,
  output lbp3_pkg::lbp3_item_t      s1_item,
  output logic [lbp3_pkg::PIX_W-1:0] s1_pix,
  output logic [AW-1:0]             s1_addr
);
  import lbp3_pkg::*;

  localparam int RW = ROW_W + 1;

  logic [AW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic             s1_valid_r;
  lbp3_item_t       s1_item_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [AW-1:0]    s1_addr_r;

  logic             in_frame;
  logic             take;
  logic             last_col;
  logic             done_pred;
  lbp3_item_t       item;
  logic [PIX_W-1:0] pix_eff;

  always_comb begin
    in_frame  = row_r < {1'b0, h_eff};
    take      = accept && !(in_frame && mode);
    last_col  = (WW'(col_r) + WW'(1)) >= w_eff;
    // the frame's last code leaves with the first item of the second row past the frame
    done_pred = (row_r == ({1'b0, h_eff} + RW'(1))) && (col_r == '0);
    item.emit     = (row_r >= RW'(2)) || ((row_r == RW'(1)) && (col_r != '0));
    item.col_zero = col_r == '0;
    pix_eff   = in_frame ? pixel : '0;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    priority if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (take) begin
      priority if (done_pred) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (advance) begin
        s1_valid_r <= take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item_r <= item;
      s1_pix_r  <= pix_eff;
      s1_addr_r <= col_r;
    end
  end

  assign rd_en    = take;
  assign rd_addr  = col_r;
  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;
  assign s1_pix   = s1_pix_r;
  assign s1_addr  = s1_addr_r;

endmodule

### rtl/core/lbp3_line_store.sv
// ----------------------------------------------------------------------------
// lbp3_line_store
// Two row buffers with registered reads. Each item reads its column, then
// writes the middle value up and its own pixel into the middle row.
// ----------------------------------------------------------------------------
module lbp3_line_store #(
  parameter int MAX_WIDTH = 1024,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [lbp3_pkg::PIX_W-1:0] wr_pix,
  output logic [lbp3_pkg::PIX_W-1:0] top,
  output logic [lbp3_pkg::PIX_W-1:0] mid
);
  import lbp3_pkg::*;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [PIX_W-1:0] upper_q_r;
  logic [PIX_W-1:0] middle_q_r;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd_top_r;
  logic [PIX_W-1:0] fwd_mid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= mid;
      middle_mem[wr_addr] <= wr_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_q_r  <= upper_mem[rd_addr];
      middle_q_r <= middle_mem[rd_addr];
    end
  end

  // same column written and read in one cycle (one-pixel rows): bypass the array
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_top_r <= mid;
      fwd_mid_r <= wr_pix;
    end
  end

  assign top = fwd_r ? fwd_top_r : upper_q_r;
  assign mid = fwd_r ? fwd_mid_r : middle_q_r;

endmodule

### rtl/core/lbp3_window.sv
// ----------------------------------------------------------------------------
// lbp3_window
// 3x3 neighbour window, output raster position, pattern compare and the
// output register.
// ----------------------------------------------------------------------------
module lbp3_window #(
  parameter int MAX_WIDTH = 1024,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [WW-1:0]               w_eff,
  input  logic [lbp3_pkg::ROW_W-1:0]  h_eff,
  input  logic                        restart,
  input  logic                        advance,
  input  logic                        s1_valid,
  input  lbp3_pkg::lbp3_item_t        s1_item,
  input  logic [lbp3_pkg::PIX_W-1:0]  s1_pix,
  input  logic [lbp3_pkg::PIX_W-1:0]  top,
  input  logic [lbp3_pkg::PIX_W-1:0]  mid,
  output logic                        out_valid,
  output logic [lbp3_pkg::CODE_W-1:0] out_code,
  output logic                        out_last
);
  import lbp3_pkg::*;

  // index = column * 3 + row, column 0 oldest, row 0 top
  logic [PIX_W-1:0]  win_r [9];
  logic [AW-1:0]     ocol_r;
  logic [ROW_W-1:0]  orow_r;
  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_last_r;

  logic              fire;
  logic              l_in, r_in, t_in, b_in;
  logic              last_col;
  logic              done;
  logic [PIX_W-1:0]  c;
  logic [CODE_W-1:0] code;

  always_comb begin
    fire     = s1_valid && advance;
    c        = win_r[7];
    last_col = (WW'(ocol_r) + WW'(1)) >= w_eff;
    l_in     = ocol_r != '0;
    r_in     = !s1_item.col_zero && !last_col;
    t_in     = orow_r != '0;
    b_in     = ({1'b0, orow_r} + (ROW_W + 1)'(1)) < {1'b0, h_eff};
    done     = last_col && !b_in;
    // left and centre columns are the same either way; the right column is
    // the column being read in now, or outside the frame at column zero
    code[7] = l_in && t_in && (win_r[3] >= c);  // top-left
    code[6] = t_in && (win_r[6] >= c);          // top
    code[5] = r_in && t_in && (top >= c);       // top-right
    code[4] = r_in && (mid >= c);               // right
    code[3] = r_in && b_in && (s1_pix >= c);    // bottom-right
    code[2] = b_in && (win_r[8] >= c);          // bottom
    code[1] = l_in && b_in && (win_r[5] >= c);  // bottom-left
    code[0] = l_in && (win_r[4] >= c);          // left
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
      ocol_r      <= '0;
      orow_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (restart || (fire && s1_item.emit && done)) begin
        for (int i = 0; i < 9; i++) begin
          win_r[i] <= '0;
        end
        ocol_r <= '0;
        orow_r <= '0;
      end else if (fire) begin
        for (int i = 0; i < 6; i++) begin
          win_r[i] <= win_r[i+3];
        end
        win_r[6] <= top;
        win_r[7] <= mid;
        win_r[8] <= s1_pix;
        if (s1_item.emit) begin
          if (last_col) begin
            ocol_r <= '0;
            orow_r <= orow_r + ROW_W'(1);
          end else begin
            ocol_r <= ocol_r + AW'(1);
          end
        end
      end
      if (advance) begin
        out_valid_r <= fire && s1_item.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire && s1_item.emit) begin
      out_code_r <= code;
      out_last_r <= done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_last  = out_last_r;

endmodule
